>>> src/dedup_ready_channel_queue_unit_macros.svh
// assertion macros shared by the dedup ready channel queue rtl
// no dependencies; included inside module bodies that check their own logic
`ifndef DEDUP_READY_CHANNEL_QUEUE_UNIT_MACROS_SVH
`define DEDUP_READY_CHANNEL_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define DRCQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define DRCQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/drcq_pkg.sv
// types and constants of the dedup ready channel queue
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package drcq_pkg;

    localparam int CH_W = 6;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [CH_W-1:0] channel_index;
    } cmd_t;

    typedef struct packed {
        logic [CH_W-1:0] out_channel;
        logic            out_valid;
        logic            duplicate_dropped;
        logic            became_available;
        logic            gate_available;
        logic            more_pending;
    } rsp_t;

endpackage

`default_nettype wire

>>> src/drcq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; used for the ready channel fifo
`timescale 1ns / 1ps
`default_nettype none

module drcq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/dedup_ready_channel_queue_unit.sv
// Deduplicating ready channel queue: fifo of channel indices plus membership bitmap.
// cmd carries an enqueue or dequeue; rsp carries one result per cmd.
// The cmd channel takes one beat per cycle while the rsp register is empty or drains.
// The result of an accepted beat is registered and shown from the next cycle; a dequeue's
// channel comes from the fifo ram read issued at the accept edge, registered in the ram.
// Throughput: one beat per cycle unless stalled; one ram access, one bitmap test per beat.
// An enqueue of a channel already queued is dropped and flagged; a channel at or above
// NUM_CHANNELS is ignored. A dequeue on an empty queue clears the availability flag.
// The bitmap bit of a popped channel is cleared while its result sits in the rsp
// register; a following enqueue sees that clear through a bypass.
// Reset: fifo empty, bitmap and flag clear, no result pending; no clearing pass,
// cmd_ready is high right after reset. Fifo ram contents need no reset.
// Stall: while rsp_valid is high and rsp_ready low, the result holds and cmd_ready is low.
// Depends on drcq_pkg, drcq_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module dedup_ready_channel_queue_unit #(
    parameter int NUM_CHANNELS = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire drcq_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output drcq_pkg::rsp_t      rsp
);

    import drcq_pkg::*;

    `include "dedup_ready_channel_queue_unit_macros.svh"

    // only channels that fit the index field can ever be queued
    localparam int LIVE_CH = (NUM_CHANNELS < (1 << CH_W)) ? NUM_CHANNELS : (1 << CH_W);
    localparam int IDX_W   = $clog2(LIVE_CH);
    localparam int CNT_W   = $clog2(LIVE_CH + 1);

    typedef struct packed {
        logic pop;
        logic dup;
        logic became;
        logic gate;
        logic more;
    } stat_t;

    logic [LIVE_CH-1:0] bitmap_reg, bitmap_next, bitmap_eff, set_mask, clr_mask;
    logic [IDX_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               flag_reg, flag_next;
    logic               s1_valid_reg, s1_valid_next;
    stat_t              stat_reg, stat_next;
    logic [CH_W-1:0]    ram_q;

    logic               accept, is_enq, ch_ok, hit, empty;
    logic               enq_ok, deq_ok, deq_empty;
    logic [IDX_W-1:0]   ch_idx;

    assign cmd_ready = !s1_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign is_enq    = (cmd.operation == OP_ENQUEUE);
    assign ch_ok     = (int'(cmd.channel_index) < NUM_CHANNELS);
    assign ch_idx    = cmd.channel_index[IDX_W-1:0];
    assign empty     = (count_reg == '0);

    // pending clear of the channel whose pop result is in the rsp register
    always_comb
    begin
        clr_mask = '0;
        if (s1_valid_reg && stat_reg.pop)
        begin
            clr_mask[ram_q[IDX_W-1:0]] = 1'b1;
        end
    end

    assign bitmap_eff = bitmap_reg & ~clr_mask;
    assign hit        = ch_ok && bitmap_eff[ch_idx];

    assign enq_ok    = accept && is_enq && ch_ok && !hit;
    assign deq_ok    = accept && !is_enq && !empty;
    assign deq_empty = accept && !is_enq && empty;

    always_comb
    begin
        set_mask = '0;
        if (enq_ok)
        begin
            set_mask[ch_idx] = 1'b1;
        end
    end

    assign bitmap_next = bitmap_eff | set_mask;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (enq_ok)
        begin
            tail_next  = (tail_reg == IDX_W'(LIVE_CH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (deq_ok)
        begin
            head_next  = (head_reg == IDX_W'(LIVE_CH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        priority if (enq_ok && empty)
        begin
            flag_next = 1'b1;
        end
        else if (deq_empty)
        begin
            flag_next = 1'b0;
        end
        else
        begin
            flag_next = flag_reg;
        end
    end

    always_comb
    begin
        stat_next.pop    = deq_ok;
        stat_next.dup    = accept && is_enq && hit;
        stat_next.became = enq_ok && empty;
        stat_next.gate   = flag_next;
        stat_next.more   = (count_next != '0);
    end

    always_comb
    begin
        priority if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg   <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            flag_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            bitmap_reg   <= bitmap_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            flag_reg     <= flag_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stat_reg <= stat_next;
        end
    end

    // read data only moves on a new pop, so it holds through a stall
    drcq_ram #(
        .WIDTH (CH_W),
        .DEPTH (LIVE_CH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (enq_ok),
        .waddr (tail_reg),
        .wdata (cmd.channel_index),
        .re    (deq_ok),
        .raddr (head_reg),
        .rdata (ram_q)
    );

    assign rsp_valid             = s1_valid_reg;
    assign rsp.out_channel       = stat_reg.pop ? ram_q : '0;
    assign rsp.out_valid         = stat_reg.pop;
    assign rsp.duplicate_dropped = stat_reg.dup;
    assign rsp.became_available  = stat_reg.became;
    assign rsp.gate_available    = stat_reg.gate;
    assign rsp.more_pending      = stat_reg.more;

    `DRCQ_ASSERT_IMP(a_empty_ptrs, clk, rst_n, count_reg == '0, head_reg == tail_reg,
        "empty queue with head and tail apart")
    `DRCQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, int'(count_reg) <= LIVE_CH,
        "entry count above channel count")
    `DRCQ_ASSERT_IMP(a_bitmap_exact, clk, rst_n, !(s1_valid_reg && stat_reg.pop),
        $countones(bitmap_reg) == int'(count_reg), "bitmap out of step with entry count")
    `DRCQ_ASSERT_IMP(a_bitmap_pop, clk, rst_n, s1_valid_reg && stat_reg.pop,
        $countones(bitmap_reg) == int'(count_reg) ||
        $countones(bitmap_reg) == int'(count_reg) + 1, "bitmap off by more than a pop")
    `DRCQ_ASSERT_NXT(a_became_gate, clk, rst_n, accept && stat_next.became,
        rsp_valid && rsp.more_pending && rsp.gate_available && !rsp.duplicate_dropped,
        "became available without pending entry and raised flag")

endmodule

`default_nettype wire
